### src/rf_pkg.sv
// Package for the Rastrigin fitness block: payload structs, register indexes,
// cosine table constants. Used by every module under src.
`default_nettype none
package rf_pkg;
	typedef struct packed {
		logic [31:0] gene;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] fitness;
		logic [6:0]  gene_count;
	} out_item_t;

	typedef enum logic [1:0] {
		REG_VALUE_MIN = 2'd0,
		REG_VALUE_MAX = 2'd1,
		REG_AMPLITUDE = 2'd2
	} reg_idx_t;

	localparam logic signed [23:0] VALUE_MIN_RST = -24'sd335544;
	localparam logic signed [23:0] VALUE_MAX_RST = 24'sd335544;
	localparam logic [7:0]         AMPLITUDE_RST = 8'd10;

	localparam longint COEF1 = 64'd1324675880;
	localparam longint COEF2 = 64'd272375599;
	localparam longint COEF3 = 64'd22401994;
	localparam longint COEF4 = 64'd987052;
	localparam longint COEF5 = 64'd27060;
	localparam longint Q30_ONE = 64'd1073741824;

	// Quarter-wave cosine entry, Q1.16; evaluated at elaboration only.
	function automatic logic [16:0] quarter_cos(input int k, input int bits);
		longint t;
		longint u;
		longint r;
		longint v;
		t = longint'(k) <<< (30 - bits);
		u = (t * t) >>> 30;
		r = COEF4 - ((u * COEF5) >>> 30);
		r = COEF3 - ((u * r) >>> 30);
		r = COEF2 - ((u * r) >>> 30);
		r = COEF1 - ((u * r) >>> 30);
		if (r < 0) r = 0;
		v = Q30_ONE - ((u * r) >>> 30);
		if (v < 0) v = 0;
		if (v > Q30_ONE) v = Q30_ONE;
		return 17'((v + 8192) >>> 14);
	endfunction
endpackage
`default_nettype wire

### src/rf_front.sv
// Front end: takes genes, maps each to x (Q8.16) by multiplying with a fixed
// reciprocal of RAND_SCALE over four partial products and one correction step.
// Depends on rf_pkg.
`default_nettype none
module rf_front #(
	parameter int unsigned RAND_SCALE = 32'd2147483647
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire rf_pkg::in_item_t    in_item,
	input  wire logic signed [23:0]  value_min,
	input  wire logic signed [23:0]  value_max,
	output logic                     x_valid,
	input  wire logic                x_ready,
	output logic signed [23:0]       x_val,
	output logic                     x_last
);
	localparam logic [31:0] SCALE = 32'(RAND_SCALE);
	// floor(2^57 / SCALE): the estimate is off by at most one below the quotient
	localparam logic [57:0] RECIP = (58'd1 << 57) / 58'(SCALE);
	// at or above this the quotient is 2^25 or more and x saturates anyway
	localparam logic [57:0] BIG_LIM = 58'(SCALE) << 25;

	logic busy_q, done_q, last_q, neg_q;
	logic [2:0] step_q;
	logic [56:0] num_q;
	logic [114:0] acc_q;
	logic [25:0] quo_q;
	logic signed [23:0] lo_q;
	logic signed [24:0] range;
	logic [24:0] mag;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [114:0] pp_sh;
	logic [24:0] qe;
	logic [56:0] qd_full;
	logic [33:0] rem;
	logic big;
	logic [25:0] quo_n;
	logic signed [58:0] xs;

	assign range = 25'(value_max) - 25'(value_min);
	assign mag = range[24] ? 25'(-range) : range;
	assign full = busy_q | done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (push && !full) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			step_q <= step_q + 3'd1;
		end else if (done_q && x_ready) begin
			done_q <= 1'b0;
		end
	end

	// one 32x32 partial product of numerator and reciprocal per step
	always_comb begin
		case (step_q)
			3'd0: begin
				pa = num_q[31:0];
				pb = RECIP[31:0];
			end
			3'd1: begin
				pa = num_q[31:0];
				pb = 32'(RECIP[57:32]);
			end
			3'd2: begin
				pa = 32'(num_q[56:32]);
				pb = RECIP[31:0];
			end
			default: begin
				pa = 32'(num_q[56:32]);
				pb = 32'(RECIP[57:32]);
			end
		endcase
	end

	assign pp = 64'(pa) * 64'(pb);

	always_comb begin
		case (step_q)
			3'd0: pp_sh = 115'(pp);
			3'd1, 3'd2: pp_sh = {19'b0, pp, 32'b0};
			default: pp_sh = {pp[50:0], 64'b0};
		endcase
	end

	// fix the estimate up by one where the remainder still covers the divisor
	assign qe = acc_q[81:57];
	assign big = 58'(num_q) >= BIG_LIM;
	assign qd_full = 57'(qe) * 57'(SCALE);
	assign rem = num_q[33:0] - qd_full[33:0];
	assign quo_n = big ? 26'h2000000 : {1'b0, qe} + 26'(rem >= 34'(SCALE));

	always_ff @(posedge clk) begin
		if (push && !full) begin
			num_q  <= 57'(in_item.gene) * 57'(mag);
			acc_q  <= '0;
			lo_q   <= value_min;
			neg_q  <= range[24];
			last_q <= in_item.last;
		end else if (busy_q) begin
			if (step_q == 3'd4) quo_q <= quo_n;
			else acc_q <= acc_q + pp_sh;
		end
	end

	assign xs = 59'(lo_q) + (neg_q ? -$signed(59'(quo_q)) : $signed(59'(quo_q)));
	always_comb begin
		if (xs > 59'sd8388607) x_val = 24'sh7FFFFF;
		else if (xs < -59'sd8388608) x_val = -24'sh800000;
		else x_val = xs[23:0];
	end
	assign x_valid = done_q;
	assign x_last = last_q;
endmodule
`default_nettype wire

### src/rf_back.sv
// Back end: squares x, looks up the cosine, accumulates and emits results.
// Depends on rf_pkg.
`default_nettype none
module rf_back #(
	parameter int MAX_GENES = 16,
	parameter int COS_TABLE_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               x_valid,
	output logic                    x_ready,
	input  wire logic signed [23:0] x_val,
	input  wire logic               x_last,
	input  wire logic [7:0]         amplitude,
	output logic                    empty,
	input  wire logic               pop,
	output rf_pkg::out_item_t       out_item
);
	localparam int N = 1 << COS_TABLE_BITS;
	localparam int KW = COS_TABLE_BITS + 1;

	logic [16:0] cos_tab [N+1];
	for (genvar i = 0; i <= N; i++) begin : g_tab
		assign cos_tab[i] = rf_pkg::quarter_cos(i, COS_TABLE_BITS);
	end

	// stage 1: square and cosine table read
	logic v_s1, last_s1;
	logic [31:0] sq_s1;
	logic [16:0] tab_s1;
	logic neg_s1;
	logic [23:0] ax;
	logic [15:0] frac;
	logic [COS_TABLE_BITS+1:0] ph;
	logic [KW-1:0] kk, kn, addr;
	logic neg_n;
	logic [47:0] sq_full;

	assign ax = x_val[23] ? 24'(-x_val) : x_val;
	assign sq_full = 48'(ax) * 48'(ax);
	assign frac = x_val[15:0];
	assign ph = (COS_TABLE_BITS+2)'(frac >> (14 - COS_TABLE_BITS));
	assign kk = {1'b0, ph[COS_TABLE_BITS-1:0]};
	assign kn = KW'(N) - kk;
	// odd quadrants read the mirrored entry, the middle two negate it
	assign addr = ph[COS_TABLE_BITS] ? kn : kk;
	assign neg_n = ph[COS_TABLE_BITS+1] ^ ph[COS_TABLE_BITS];

	// stage 2: term
	logic v_s2, last_s2;
	logic [32:0] term_s2;
	logic [18:0] oc;
	assign oc = neg_s1 ? 19'd65536 + 19'(tab_s1) : 19'd65536 - 19'(tab_s1);

	logic out_v_q;
	logic [31:0] sum_q;
	logic [6:0] cnt_q;
	logic [32:0] s;
	logic [31:0] ssat;
	logic [6:0] cnt_n;
	logic stall;

	assign s = 33'(sum_q) + term_s2;
	assign ssat = (s[32] || term_s2[32]) ? 32'hFFFFFFFF : s[31:0];
	assign cnt_n = (cnt_q < 7'(MAX_GENES)) ? cnt_q + 7'd1 : cnt_q;
	assign stall = v_s2 && last_s2 && out_v_q && !pop;
	assign x_ready = !stall;
	assign empty = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (out_v_q && pop) out_v_q <= 1'b0;
			if (!stall) begin
				v_s1 <= x_valid;
				v_s2 <= v_s1;
				if (v_s2) begin
					if (last_s2) begin
						out_v_q <= 1'b1;
						sum_q <= '0;
						cnt_q <= '0;
					end else begin
						sum_q <= ssat;
						cnt_q <= cnt_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			last_s1 <= x_last;
			sq_s1 <= sq_full[47:16];
			tab_s1 <= cos_tab[addr];
			neg_s1 <= neg_n;
			last_s2 <= last_s1;
			term_s2 <= 33'(sq_s1) + 33'(amplitude) * 33'(oc);
			if (v_s2 && last_s2) begin
				out_item <= '{fitness: ssat, gene_count: cnt_n};
			end
		end
	end
endmodule
`default_nettype wire

### src/rastrigin_fitness.sv
// Rastrigin fitness top level: config registers, front mapper, back accumulator.
// The front maps x in four partial products, one correction and one handoff,
// and takes no new gene until it has handed its x to the back end. Results
// wait in an output register until popped; a second last gene stalls behind
// an unpopped result. Reset (arst_n low) clears the sum, count and pipeline;
// registers reload defaults.
`default_nettype none
module rastrigin_fitness #(
	parameter int MAX_GENES = 16,
	parameter int unsigned RAND_SCALE = 32'd2147483647,
	parameter int COS_TABLE_BITS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire rf_pkg::in_item_t  in_item,
	output logic                   empty,
	input  wire logic              pop,
	output rf_pkg::out_item_t      out_item,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [23:0]       cfg_data
);
	logic signed [23:0] vmin_q, vmax_q;
	logic [7:0] amp_q;
	logic xv, xr, xl;
	logic signed [23:0] xval;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q <= rf_pkg::VALUE_MIN_RST;
			vmax_q <= rf_pkg::VALUE_MAX_RST;
			amp_q  <= rf_pkg::AMPLITUDE_RST;
		end else if (cfg_valid) begin
			case (rf_pkg::reg_idx_t'(cfg_index))
				rf_pkg::REG_VALUE_MIN: vmin_q <= cfg_data;
				rf_pkg::REG_VALUE_MAX: vmax_q <= cfg_data;
				rf_pkg::REG_AMPLITUDE: amp_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	rf_front #(.RAND_SCALE(RAND_SCALE)) u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.value_min(vmin_q), .value_max(vmax_q),
		.x_valid(xv), .x_ready(xr), .x_val(xval), .x_last(xl)
	);

	rf_back #(.MAX_GENES(MAX_GENES), .COS_TABLE_BITS(COS_TABLE_BITS)) u_back (
		.clk, .arst_n, .x_valid(xv), .x_ready(xr), .x_val(xval), .x_last(xl),
		.amplitude(amp_q), .empty, .pop, .out_item
	);
endmodule
`default_nettype wire

### src/rf_checker.sv
// Port-level checks for rastrigin_fitness; bound to the top level below.
// Depends on rf_pkg.
`default_nettype none
module rf_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire logic             empty,
	input wire logic             pop,
	input wire rf_pkg::out_item_t out_item
);
	// a transfer into the divider keeps the input closed next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full) else $error("accepted while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item)) else $error("result changed");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.gene_count != 7'd0) else $error("zero gene count");
endmodule

bind rastrigin_fitness rf_checker u_rf_checker (
	.clk, .arst_n, .push, .full, .empty, .pop, .out_item
);
`default_nettype wire
